FILE: rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg: shared types and constants for the page frame bitmap allocator
// Command and result payload structs, operation and status codes, defaults.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Default map geometry
  localparam int MAP_WORDS_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam logic [31:0] NONE_FREE = 32'hFFFF_FFFF;
  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_SET_USED   = 2'd1,
    OP_FREE       = 2'd2,
    OP_FREE_RANGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_FRAMES = 2'd1,
    ST_ALREADY_USED  = 2'd2,
    ST_DOUBLE_FREE   = 2'd3
  } status_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] address;
    logic [31:0] length;
    logic        reuse_allowed;
  } cmd_t;

  typedef struct packed {
    logic [31:0] frame_address;
    status_t     status;
  } result_t;

endpackage

FILE: rtl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page frame allocator over a used-bit map held in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present cmd with start high; the transaction is taken at
//   a clock edge where start is high and busy is low. Each command yields one
//   result, shown on result for one cycle with done high; the receiver
//   cannot stall it, so it must capture the result in that cycle.
//   Config channel: cfg_valid/cfg_ready (always ready) writes the double
//   free report enable from cfg_data; write it only while the block is idle.
//   Steps from accept to done:
//     alloc           : reads map words one by one, starting at the lowest
//                       word that may hold a free frame (no read when none free)
//     set used / free : a read and a write, only a read for a frame beyond the map
//     free range      : a read and a write per page in the map and a read per page
//                       past it, up to a reported double free; empty range: no read
//   One command is in flight at a time: busy is low in the done cycle, so
//   the next command can be taken at the edge that ends it. The map RAM has a
//   read port and a write port used as read/modify/write: alloc scans one
//   word per cycle, page updates take a read and a write.
//   Reset: rst (synchronous) starts a fill pass that writes all ones into
//   the map, one word per cycle; busy is high meanwhile and config writes
//   are still taken.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int MAP_WORDS  = MAP_WORDS_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data,
  output logic    done,
  output result_t result
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FW = 32 - PAGE_SHIFT;
  localparam logic [AW:0] HINT_NONE = (AW + 1)'(MAP_WORDS);

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_SCAN    = 5'b00100,
    S_PAGE_RD = 5'b01000,
    S_PAGE_WR = 5'b10000
  } state_t;

  state_t        state;
  logic [AW-1:0] clr;
  logic [AW:0]   hint;
  logic [AW-1:0] scan_addr;
  logic          report_double_free;
  op_t           op_q;
  logic          reuse_q;
  logic [FW-1:0] cur;
  logic [FW-1:0] cnt;

  // Map RAM
  logic [31:0]   mem [MAP_WORDS];
  logic [31:0]   rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [AW-1:0] mem_ra;

  logic [31:0]   cur_word32;
  logic          cur_in_map;
  logic [AW-1:0] cur_addr;
  logic [31:0]   cur_bit;
  logic          bit_set;
  logic [AW:0]   scan_next;
  logic [4:0]    free_bit;
  logic [AW+4:0] grant_frame;
  logic [63:0]   alloc_wide;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Decode the current frame and the scanned word
  always_comb begin
    cur_word32  = 32'(cur >> 5);
    cur_in_map  = (cur_word32 < 32'(MAP_WORDS));
    cur_addr    = cur_word32[AW-1:0];
    cur_bit     = 32'(1) << cur[4:0];
    bit_set     = |(rd_q & cur_bit);
    scan_next   = {1'b0, scan_addr} + (AW + 1)'(1);
    free_bit    = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!rd_q[i]) free_bit = 5'(i);
    end
    grant_frame = {scan_addr, free_bit};
    alloc_wide  = 64'(grant_frame) << PAGE_SHIFT;
  end

  // Drive the RAM ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_addr;
    mem_wd = rd_q;
    mem_ra = cur_addr;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr;
        mem_wd = FULL_WORD;
      end
      S_IDLE: begin
        mem_ra = hint[AW-1:0];
      end
      S_SCAN: begin
        mem_ra = scan_next[AW-1:0];
        if (rd_q != FULL_WORD) begin
          mem_we = 1'b1;
          mem_wa = scan_addr;
          mem_wd = rd_q | (32'(1) << free_bit);
        end
      end
      S_PAGE_RD: begin
        mem_ra = cur_addr;
      end
      S_PAGE_WR: begin
        if (op_q == OP_SET_USED) begin
          mem_we = !bit_set;
          mem_wd = rd_q | cur_bit;
        end else begin
          mem_we = bit_set;
          mem_wd = rd_q & ~cur_bit;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      clr                <= '0;
      hint               <= HINT_NONE;
      report_double_free <= 1'b0;
      done               <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) report_double_free <= cfg_data;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(MAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= cmd.operation;
            reuse_q <= cmd.reuse_allowed;
            cur     <= cmd.address[31:PAGE_SHIFT];
            cnt     <= cmd.length[31:PAGE_SHIFT];
            if (cmd.operation == OP_ALLOC) begin
              if (hint == HINT_NONE) begin
                done                 <= 1'b1;
                result.frame_address <= NONE_FREE;
                result.status        <= ST_OUT_OF_FRAMES;
              end else begin
                scan_addr <= hint[AW-1:0];
                state     <= S_SCAN;
              end
            end else if (cmd.operation == OP_FREE_RANGE &&
                         cmd.length[31:PAGE_SHIFT] == '0) begin
              done                 <= 1'b1;
              result.frame_address <= '0;
              result.status        <= ST_OK;
            end else begin
              state <= S_PAGE_RD;
            end
          end
        end
        S_SCAN: begin
          if (rd_q != FULL_WORD) begin
            hint                 <= {1'b0, scan_addr};
            done                 <= 1'b1;
            result.frame_address <= alloc_wide[31:0];
            result.status        <= ST_OK;
            state                <= S_IDLE;
          end else if (scan_next == HINT_NONE) begin
            hint                 <= HINT_NONE;
            done                 <= 1'b1;
            result.frame_address <= NONE_FREE;
            result.status        <= ST_OUT_OF_FRAMES;
            state                <= S_IDLE;
          end else begin
            scan_addr <= scan_next[AW-1:0];
          end
        end
        S_PAGE_RD: begin
          if (cur_in_map) begin
            state <= S_PAGE_WR;
          end else if (op_q == OP_FREE_RANGE && cnt != FW'(1)) begin
            // skip frames past the end of the map
            cnt <= cnt - FW'(1);
            cur <= cur + FW'(1);
          end else begin
            done                 <= 1'b1;
            result.frame_address <= '0;
            result.status        <= ST_OK;
            state                <= S_IDLE;
          end
        end
        S_PAGE_WR: begin
          result.frame_address <= '0;
          case (op_q)
            OP_SET_USED: begin
              done          <= 1'b1;
              result.status <= (bit_set && !reuse_q) ? ST_ALREADY_USED : ST_OK;
              state         <= S_IDLE;
            end
            OP_FREE: begin
              if (bit_set && ({1'b0, cur_addr} < hint)) hint <= {1'b0, cur_addr};
              done          <= 1'b1;
              result.status <= (!bit_set && report_double_free) ? ST_DOUBLE_FREE : ST_OK;
              state         <= S_IDLE;
            end
            default: begin
              if (bit_set && ({1'b0, cur_addr} < hint)) hint <= {1'b0, cur_addr};
              if (!bit_set && report_double_free) begin
                done          <= 1'b1;
                result.status <= ST_DOUBLE_FREE;
                state         <= S_IDLE;
              end else if (cnt == FW'(1)) begin
                done          <= 1'b1;
                result.status <= ST_OK;
                state         <= S_IDLE;
              end else begin
                cnt   <= cnt - FW'(1);
                cur   <= cur + FW'(1);
                state <= S_PAGE_RD;
              end
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An alloc on a known full map answers out of frames on the next cycle
  a_alloc_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && cmd.operation == OP_ALLOC && hint == HINT_NONE)
    |=> (done && result.status == ST_OUT_OF_FRAMES))
    else $error("alloc on full map did not report out of frames");

  // Out of frames always carries the none-free address
  a_oof_addr: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_OUT_OF_FRAMES) |-> (result.frame_address == NONE_FREE))
    else $error("out of frames result with a frame address");

  // The map is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("map write while idle");

  // The free hint stays within the map or equals the none-free value MAP_WORDS
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    hint <= HINT_NONE)
    else $error("free hint beyond map size");
`endif

endmodule
